### hdl/mmbd_pkg.sv
// Package for the memory map bus decoder: map constants, region codes,
// address decode function and the request/read-data structs.
// No dependencies.
package mmbd_pkg;

  // Store depths and index widths
  localparam int CART_DEPTH = 65536;
  localparam int WRAM_DEPTH = 8192;
  localparam int HRAM_DEPTH = 128;
  localparam int CART_AW    = $clog2(CART_DEPTH);
  localparam int WRAM_AW    = $clog2(WRAM_DEPTH);
  localparam int HRAM_AW    = $clog2(HRAM_DEPTH);

  // Memory map boundaries
  localparam logic [15:0] VRAM_BASE  = 16'h8000;
  localparam logic [15:0] ERAM_BASE  = 16'hA000;
  localparam logic [15:0] WRAM_BASE  = 16'hC000;
  localparam logic [15:0] ECHO_BASE  = 16'hE000;
  localparam logic [15:0] OAM_BASE   = 16'hFE00;
  localparam logic [15:0] UNUSE_BASE = 16'hFEA0;
  localparam logic [15:0] IO_BASE    = 16'hFF00;
  localparam logic [15:0] HRAM_BASE  = 16'hFF80;
  localparam logic [15:0] IE_ADDR    = 16'hFFFF;
  localparam logic [15:0] SER0_ADDR  = 16'hFF01;
  localparam logic [15:0] SER1_ADDR  = 16'hFF02;
  localparam logic [15:0] IF_ADDR    = 16'hFF0F;
  localparam logic [15:0] LY_ADDR    = 16'hFF44;
  localparam logic [15:0] TIMER_LO   = 16'hFF04;
  localparam logic [15:0] TIMER_HI   = 16'hFF07;
  localparam logic [7:0]  LY_VALUE   = 8'h90;

  // Access kinds
  localparam logic KIND_READ  = 1'b0;
  localparam logic KIND_WRITE = 1'b1;

  // Decoded regions
  localparam logic [3:0] RG_NONE  = 4'd0;
  localparam logic [3:0] RG_CART  = 4'd1;
  localparam logic [3:0] RG_WRAM  = 4'd2;
  localparam logic [3:0] RG_HRAM  = 4'd3;
  localparam logic [3:0] RG_SER0  = 4'd4;
  localparam logic [3:0] RG_SER1  = 4'd5;
  localparam logic [3:0] RG_IF    = 4'd6;
  localparam logic [3:0] RG_IE    = 4'd7;
  localparam logic [3:0] RG_LY    = 4'd8;
  localparam logic [3:0] RG_TIMER = 4'd9;

  // Access toward the memory block
  typedef struct packed {
    logic                cart_en;
    logic                wram_en;
    logic                hram_en;
    logic                we;
    logic [CART_AW-1:0]  addr;
    logic [7:0]          wdata;
  } mmbd_req_t;

  // Registered read data from the memories
  typedef struct packed {
    logic [7:0] cart;
    logic [7:0] wram;
    logic [7:0] hram;
  } mmbd_rdata_t;

  // Address decode; timer range takes priority over everything
  function automatic logic [3:0] decode_region(input logic [15:0] a);
    logic [3:0] r;
    if (a inside {[TIMER_LO:TIMER_HI]}) r = RG_TIMER;
    else if (a == LY_ADDR)              r = RG_LY;
    else if (a < VRAM_BASE)             r = RG_CART;
    else if (a < ERAM_BASE)             r = RG_NONE;
    else if (a < WRAM_BASE)             r = RG_CART;
    else if (a < ECHO_BASE)             r = RG_WRAM;
    else if (a < OAM_BASE)              r = RG_WRAM;   // echo of work RAM
    else if (a < UNUSE_BASE)            r = RG_NONE;   // OAM
    else if (a < IO_BASE)               r = RG_NONE;   // unusable
    else if (a < HRAM_BASE) begin
      if (a == SER0_ADDR)      r = RG_SER0;
      else if (a == SER1_ADDR) r = RG_SER1;
      else if (a == IF_ADDR)   r = RG_IF;
      else                     r = RG_NONE;
    end
    else if (a == IE_ADDR)              r = RG_IE;
    else                                r = RG_HRAM;
    return r;
  endfunction

endpackage

### hdl/mmbd_store.sv
// Memory block of the bus decoder: cartridge store, work RAM and high RAM,
// each a synchronous single-port RAM, plus the zero sweep after reset.
// Depends on mmbd_pkg.
module mmbd_store (
  input  logic                clk,
  input  logic                rst_n,
  input  mmbd_pkg::mmbd_req_t req,
  output logic                ready,
  output mmbd_pkg::mmbd_rdata_t rdata
);

  logic [7:0] cart_mem [mmbd_pkg::CART_DEPTH];
  logic [7:0] wram_mem [mmbd_pkg::WRAM_DEPTH];
  logic [7:0] hram_mem [mmbd_pkg::HRAM_DEPTH];

  logic [mmbd_pkg::WRAM_AW-1:0] clr_cnt_r;
  logic                         clr_busy_r;
  logic                         clr_last;

  // Registered read data, one per RAM
  logic [7:0] cart_rd_r;
  logic [7:0] wram_rd_r;
  logic [7:0] hram_rd_r;

  assign clr_last = (clr_cnt_r == mmbd_pkg::WRAM_AW'(mmbd_pkg::WRAM_DEPTH - 1));
  assign ready    = !clr_busy_r;
  assign rdata    = '{cart: cart_rd_r, wram: wram_rd_r, hram: hram_rd_r};

  // Zero sweep over work RAM (and high RAM alongside) after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r  <= '0;
      clr_busy_r <= 1'b1;
    end else if (clr_busy_r) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
      if (clr_last) clr_busy_r <= 1'b0;
    end
  end

  // Cartridge store: no reset contents
  always_ff @(posedge clk) begin
    if (req.cart_en) begin
      if (req.we) cart_mem[req.addr] <= req.wdata;
      else        cart_rd_r          <= cart_mem[req.addr];
    end
  end

  // Work RAM
  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      wram_mem[clr_cnt_r] <= '0;
    end else if (req.wram_en) begin
      if (req.we) wram_mem[req.addr[mmbd_pkg::WRAM_AW-1:0]] <= req.wdata;
      else        wram_rd_r <= wram_mem[req.addr[mmbd_pkg::WRAM_AW-1:0]];
    end
  end

  // High RAM
  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      hram_mem[clr_cnt_r[mmbd_pkg::HRAM_AW-1:0]] <= '0;
    end else if (req.hram_en) begin
      if (req.we) hram_mem[req.addr[mmbd_pkg::HRAM_AW-1:0]] <= req.wdata;
      else        hram_rd_r <= hram_mem[req.addr[mmbd_pkg::HRAM_AW-1:0]];
    end
  end

  // No access may be issued while the sweep runs
  a_no_req_clr: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !(req.cart_en || req.wram_en || req.hram_en))
    else $error("memory access during clear sweep");

  // Sweep ends only after the last entry
  a_clr_end: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(clr_busy_r) |-> $past(clr_last))
    else $error("clear sweep ended early");

  // At most one memory enabled per access
  a_one_mem: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({req.cart_en, req.wram_en, req.hram_en}))
    else $error("more than one memory selected");

endmodule

### hdl/memory_map_bus_decoder_unit.sv
// Top level of the memory map bus decoder: stream ports, address decode,
// I/O registers and output register. Depends on mmbd_pkg and mmbd_store.
//
// Usage:
//   Input beats carry one byte access each: in_tuser is the kind (0 read,
//   1 write), in_tdata holds address and write byte. Every accepted beat
//   gives exactly one output beat: out_tdata is the read byte (zero for
//   writes and timer accesses), out_tuser flags 0xFF04-0xFF07 for an
//   external timer unit.
//   The RAM read and the memory stage register at the accepting edge;
//   the output register loads from the memory stage when it is empty or
//   out_tready is high, and out_tvalid rises with that load. Throughput:
//   one beat per cycle when the receiver keeps out_tready high; one
//   access per cycle is the limit of the single port on each RAM.
//   Reset: rst_n is synchronous, active low. Afterwards work RAM and high
//   RAM are swept to zero (8192 entries), during which in_tready stays
//   low. Cartridge store contents are undefined until written.
//   Stall: when out_tready is low the output register holds; one more
//   access can sit in the memory stage, then in_tready drops.
module memory_map_bus_decoder_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [15:0] address, [23:16] write_data
  input  logic        in_tuser,   // kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] read_data
  output logic        out_tuser   // timer_access
);

  logic [15:0] in_addr;
  logic [7:0]  in_wdata;
  logic [3:0]  in_rgn;
  logic        in_beat;
  logic        in_wr;

  mmbd_pkg::mmbd_req_t   req;
  mmbd_pkg::mmbd_rdata_t rdata;
  logic                  store_ready;

  // I/O registers
  logic [7:0] ser0_r, ser1_r, int_flag_r, int_en_r;

  // Memory stage
  logic       s1_valid_r;
  logic [3:0] s1_rgn_r;
  logic       s1_rd_r;
  logic [7:0] s1_val_r;
  logic [7:0] s1_val_nxt;
  logic       s1_adv;

  // Output register
  logic       out_valid_r;
  logic [7:0] out_data_r;
  logic       out_tmr_r;
  logic [7:0] out_data_nxt;

  assign in_addr  = in_tdata[15:0];
  assign in_wdata = in_tdata[23:16];
  assign in_rgn   = mmbd_pkg::decode_region(in_addr);
  assign in_wr    = (in_tuser == mmbd_pkg::KIND_WRITE);

  assign s1_adv    = !out_valid_r || out_tready;
  assign in_tready = store_ready && (!s1_valid_r || s1_adv);
  assign in_beat   = in_tvalid && in_tready;

  // Memory request
  always_comb begin
    req.cart_en = in_beat && (in_rgn == mmbd_pkg::RG_CART);
    req.wram_en = in_beat && (in_rgn == mmbd_pkg::RG_WRAM);
    req.hram_en = in_beat && (in_rgn == mmbd_pkg::RG_HRAM);
    req.we      = in_wr;
    req.addr    = in_addr;
    req.wdata   = in_wdata;
  end

  mmbd_store u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .ready (store_ready),
    .rdata (rdata)
  );

  // Register-mapped read value, sampled at accept
  always_comb begin
    case (in_rgn)
      mmbd_pkg::RG_SER0: s1_val_nxt = ser0_r;
      mmbd_pkg::RG_SER1: s1_val_nxt = ser1_r;
      mmbd_pkg::RG_IF:   s1_val_nxt = int_flag_r;
      mmbd_pkg::RG_IE:   s1_val_nxt = int_en_r;
      mmbd_pkg::RG_LY:   s1_val_nxt = mmbd_pkg::LY_VALUE;
      default:           s1_val_nxt = '0;
    endcase
  end

  // I/O register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ser0_r     <= '0;
      ser1_r     <= '0;
      int_flag_r <= '0;
      int_en_r   <= '0;
    end else if (in_beat && in_wr) begin
      case (in_rgn)
        mmbd_pkg::RG_SER0: ser0_r     <= in_wdata;
        mmbd_pkg::RG_SER1: ser1_r     <= in_wdata;
        mmbd_pkg::RG_IF:   int_flag_r <= in_wdata;
        mmbd_pkg::RG_IE:   int_en_r   <= in_wdata;
        default: ;
      endcase
    end
  end

  // Memory stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_beat) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      s1_rgn_r <= in_rgn;
      s1_rd_r  <= !in_wr;
      s1_val_r <= s1_val_nxt;
    end
  end

  // Result byte: memory data or sampled register value; writes give zero
  always_comb begin
    case (s1_rgn_r)
      mmbd_pkg::RG_CART: out_data_nxt = rdata.cart;
      mmbd_pkg::RG_WRAM: out_data_nxt = rdata.wram;
      mmbd_pkg::RG_HRAM: out_data_nxt = rdata.hram;
      default:           out_data_nxt = s1_val_r;
    endcase
    if (!s1_rd_r) out_data_nxt = '0;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid_r) begin
      out_data_r <= out_data_nxt;
      out_tmr_r  <= (s1_rgn_r == mmbd_pkg::RG_TIMER);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_tmr_r;

  // No beat is taken during the clear sweep
  a_no_in_clr: assert property (@(posedge clk) disable iff (!rst_n)
    !store_ready |-> !in_tready)
    else $error("input accepted during clear sweep");

  // Timer accesses return zero data
  a_tmr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == 8'h00)
    else $error("timer access returned data");

  // An accepted beat occupies the memory stage on the next cycle
  a_s1_fill: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat |=> s1_valid_r)
    else $error("accepted beat lost");

  // A stalled result is never overwritten by the memory stage
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output overrun");

endmodule
